// ----- design/chm_pkg.sv -----
// chained hash multimap: shared types, sizes and codes
// used by chm_store and chained_hash_multimap_unit; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package chm_pkg;

   localparam int BUCKETS = 256;
   localparam int ENTRIES = 128;
   localparam int KEY_W = 64;
   localparam int VALUE_W = 32;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int PTR_W = IDX_W + 1;
   localparam int BKT_W = $clog2(BUCKETS);
   localparam int CNT_W = 8;

   localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

   localparam logic [3:0] CMD_GET = 4'd0;
   localparam logic [3:0] CMD_SET = 4'd1;
   localparam logic [3:0] CMD_REMOVE = 4'd2;
   localparam logic [3:0] CMD_MULTI = 4'd3;
   localparam logic [3:0] CMD_COUNT = 4'd4;
   localparam logic [3:0] CMD_NEXT = 4'd5;
   localparam logic [3:0] CMD_REMOVE_ENTRY = 4'd6;
   localparam logic [3:0] CMD_CLEAR = 4'd7;
   localparam logic [3:0] CMD_REMOVE_ALL = 4'd8;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [3:0]       command;
      logic [KEY_W-1:0] key;
      logic [31:0]      value;
      logic [6:0]       slot_sel;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value_out;
      logic [6:0]  slot_out;
      logic [7:0]  match_count;
   } rsp_type;

   typedef struct packed {
      logic               key_we;
      logic               link_we;
      logic               val_we;
      logic [IDX_W-1:0]   addr;
      logic [KEY_W-1:0]   key;
      logic [PTR_W-1:0]   link;
      logic [VALUE_W-1:0] val;
   } ent_wr_type;

   typedef struct packed {
      logic             we;
      logic             clr;
      logic [BKT_W-1:0] addr;
      logic [PTR_W-1:0] data;
   } head_wr_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [PTR_W-1:0]   link;
      logic [VALUE_W-1:0] val;
      logic [PTR_W-1:0]   head;
   } store_rd_type;

endpackage
`default_nettype wire

// ----- design/chm_store.sv -----
// entry arrays and bucket heads with registered reads
// depends on chm_pkg; heads carry valid bits so reset and clear are immediate
`timescale 1ns / 1ps
`default_nettype none
module chm_store import chm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [IDX_W-1:0] ent_raddr,
   input  wire logic [BKT_W-1:0] head_raddr,
   input  wire ent_wr_type   ent_wr,
   input  wire head_wr_type  head_wr,
   output store_rd_type      rd
);

   logic [KEY_W-1:0]   key_mem [ENTRIES];
   logic [PTR_W-1:0]   link_mem [ENTRIES];
   logic [VALUE_W-1:0] val_mem [ENTRIES];
   logic [PTR_W-1:0]   head_mem [BUCKETS];
   logic [BUCKETS-1:0] head_ok_ff;
   logic [KEY_W-1:0]   key_q_ff;
   logic [PTR_W-1:0]   link_q_ff;
   logic [VALUE_W-1:0] val_q_ff;
   logic [PTR_W-1:0]   head_q_ff;
   logic               head_ok_q_ff;

   always_ff @(posedge clock) begin
      if (ent_wr.key_we) begin
         key_mem[ent_wr.addr] <= ent_wr.key;
      end
      if (ent_wr.link_we) begin
         link_mem[ent_wr.addr] <= ent_wr.link;
      end
      if (ent_wr.val_we) begin
         val_mem[ent_wr.addr] <= ent_wr.val;
      end
      if (head_wr.we) begin
         head_mem[head_wr.addr] <= head_wr.data;
      end
      key_q_ff <= key_mem[ent_raddr];
      link_q_ff <= link_mem[ent_raddr];
      val_q_ff <= val_mem[ent_raddr];
      head_q_ff <= head_mem[head_raddr];
      head_ok_q_ff <= head_ok_ff[head_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset || head_wr.clr) begin
         head_ok_ff <= '0;
      end else if (head_wr.we) begin
         head_ok_ff[head_wr.addr] <= 1'b1;
      end
   end

   assign rd.key = key_q_ff;
   assign rd.link = link_q_ff;
   assign rd.val = val_q_ff;
   assign rd.head = head_ok_q_ff ? head_q_ff : NIL;

endmodule
`default_nettype wire

// ----- design/chained_hash_multimap_unit.sv -----
// chained hash multimap, top level: command sequencer and chain walker
// depends on chm_pkg and chm_store
//
// req_valid/req_ready take one command item (command, key, value, slot_sel);
// rsp_valid/rsp_ready return exactly one result item per command.
// One command is worked on at a time; req_ready is high only when the
// sequencer is idle. Every chain step has a read state and a check state,
// because each entry read goes through the registered read port of the entry
// memory. get, set, count and find next walk one chain.
// remove and remove entry add a second walk (to find the predecessor of the
// last entry) and a copy. remove all repeats the remove sequence once per
// matching entry.
// Results wait in an output register; the next command is taken while an
// earlier result is still unclaimed, and the sequencer holds its next result
// back until the output register is free.
// Reset empties all bucket heads and sets the entry count to zero at once;
// the block is ready in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_multimap_unit import chm_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_item,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_item
);

   typedef enum logic [16:0] {
      S_IDLE  = 17'h00001,
      S_HRD   = 17'h00002,
      S_HWT   = 17'h00004,
      S_WRD   = 17'h00008,
      S_WCK   = 17'h00010,
      S_WEND  = 17'h00020,
      S_EIRD  = 17'h00040,
      S_EIWT  = 17'h00080,
      S_ER1   = 17'h00100,
      S_LRD   = 17'h00200,
      S_LWT   = 17'h00400,
      S_CRD   = 17'h00800,
      S_CWR   = 17'h01000,
      S_EDONE = 17'h02000,
      S_ADD   = 17'h04000,
      S_ADD2  = 17'h08000,
      S_RSP   = 17'h10000
   } state_type;

   state_type          state_ff, state_in;
   logic [3:0]         cmd_ff, cmd_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [IDX_W-1:0]   ei_ff, ei_in;
   logic [KEY_W-1:0]   cmp_key_ff, cmp_key_in;
   logic [PTR_W-1:0]   cur_ff, cur_in;
   logic [PTR_W-1:0]   prv_ff, prv_in;
   logic [PTR_W-1:0]   steps_ff, steps_in;
   logic               found_ff, found_in;
   logic [PTR_W-1:0]   x_ff, x_in;
   logic [PTR_W-1:0]   xlink_ff, xlink_in;
   logic [VALUE_W-1:0] xval_ff, xval_in;
   logic [PTR_W-1:0]   ex_ff, ex_in;
   logic               lastpred_ff, lastpred_in;
   logic [PTR_W-1:0]   used_ff, used_in;
   logic [1:0]         st_ff, st_in;
   logic [VALUE_W-1:0] rv_ff, rv_in;
   logic [IDX_W-1:0]   rs_ff, rs_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   ent_wr_type   ent_wr;
   head_wr_type  head_wr;
   store_rd_type rd;

   logic [PTR_W-1:0] last;
   logic [PTR_W-1:0] tgt;
   logic             ident;
   logic             count_mode;
   logic             match;

   chm_store u_store (
      .clock      (clock),
      .reset      (reset),
      .ent_raddr  (cur_ff[IDX_W-1:0]),
      .head_raddr (cmp_key_ff[BKT_W-1:0]),
      .ent_wr     (ent_wr),
      .head_wr    (head_wr),
      .rd         (rd)
   );

   assign last = used_ff - 1'b1;
   assign ident = lastpred_ff || (cmd_ff == CMD_REMOVE_ENTRY);
   assign count_mode = !lastpred_ff && (cmd_ff == CMD_COUNT);
   assign tgt = lastpred_ff ? last : {1'b0, ei_ff};
   assign match = ident ? (cur_ff == tgt) : (rd.key == cmp_key_ff);

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      key_in = key_ff;
      val_in = val_ff;
      ei_in = ei_ff;
      cmp_key_in = cmp_key_ff;
      cur_in = cur_ff;
      prv_in = prv_ff;
      steps_in = steps_ff;
      found_in = found_ff;
      x_in = x_ff;
      xlink_in = xlink_ff;
      xval_in = xval_ff;
      ex_in = ex_ff;
      lastpred_in = lastpred_ff;
      used_in = used_ff;
      st_in = st_ff;
      rv_in = rv_ff;
      rs_in = rs_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      ent_wr = '0;
      head_wr = '0;
      head_wr.addr = cmp_key_ff[BKT_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_item.command;
               key_in = req_item.key;
               val_in = req_item.value;
               ei_in = req_item.slot_sel;
               cmp_key_in = req_item.key;
               lastpred_in = 1'b0;
               st_in = ST_MISS;
               rv_in = '0;
               rs_in = '0;
               cnt_in = '0;
               state_in = S_RSP;
               case (req_item.command) inside
                  CMD_GET, CMD_SET, CMD_REMOVE, CMD_COUNT, CMD_REMOVE_ALL: begin
                     state_in = S_HRD;
                  end
                  CMD_MULTI: begin
                     if (used_ff >= PTR_W'(ENTRIES)) begin
                        st_in = ST_FULL;
                     end else begin
                        state_in = S_HRD;
                     end
                  end
                  CMD_NEXT, CMD_REMOVE_ENTRY: begin
                     if ({1'b0, req_item.slot_sel} < used_ff) begin
                        cur_in = {1'b0, req_item.slot_sel};
                        state_in = S_EIRD;
                     end
                  end
                  CMD_CLEAR: begin
                     head_wr.clr = 1'b1;
                     used_in = '0;
                     st_in = ST_OK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_HRD: begin
            state_in = S_HWT;
         end
         S_HWT: begin
            cur_in = rd.head;
            prv_in = NIL;
            steps_in = '0;
            found_in = 1'b0;
            state_in = S_WRD;
         end
         S_WRD: begin
            if (cur_ff < used_ff && steps_ff < PTR_W'(ENTRIES)) begin
               state_in = S_WCK;
            end else begin
               found_in = 1'b0;
               state_in = S_WEND;
            end
         end
         S_WCK: begin
            if (match && !count_mode) begin
               found_in = 1'b1;
               x_in = cur_ff;
               xlink_in = rd.link;
               xval_in = rd.val;
               state_in = S_WEND;
            end else begin
               if (match && cnt_ff != '1) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               prv_in = cur_ff;
               cur_in = rd.link;
               steps_in = steps_ff + 1'b1;
               state_in = S_WRD;
            end
         end
         S_WEND: begin
            if (lastpred_ff) begin
               if (found_ff) begin
                  if (prv_ff == NIL) begin
                     head_wr.we = 1'b1;
                     head_wr.data = ex_ff;
                  end else begin
                     ent_wr.link_we = 1'b1;
                     ent_wr.addr = prv_ff[IDX_W-1:0];
                     ent_wr.link = ex_ff;
                  end
               end
               cur_in = last;
               state_in = S_CRD;
            end else begin
               state_in = S_RSP;
               case (cmd_ff) inside
                  CMD_GET, CMD_NEXT: begin
                     if (found_ff) begin
                        st_in = ST_OK;
                        rs_in = x_ff[IDX_W-1:0];
                        rv_in = xval_ff;
                     end
                  end
                  CMD_SET: begin
                     if (found_ff) begin
                        ent_wr.val_we = 1'b1;
                        ent_wr.addr = x_ff[IDX_W-1:0];
                        ent_wr.val = val_ff;
                        st_in = ST_OK;
                        rs_in = x_ff[IDX_W-1:0];
                        rv_in = val_ff;
                     end else if (used_ff >= PTR_W'(ENTRIES)) begin
                        st_in = ST_FULL;
                     end else begin
                        state_in = S_ADD;
                     end
                  end
                  CMD_REMOVE, CMD_REMOVE_ENTRY: begin
                     if (found_ff) begin
                        st_in = ST_OK;
                        rs_in = x_ff[IDX_W-1:0];
                        rv_in = xval_ff;
                        state_in = S_ER1;
                     end
                  end
                  CMD_MULTI: begin
                     state_in = S_ADD;
                  end
                  CMD_COUNT: begin
                     st_in = ST_OK;
                  end
                  CMD_REMOVE_ALL: begin
                     if (found_ff) begin
                        state_in = S_ER1;
                     end else begin
                        st_in = (cnt_ff != '0) ? ST_OK : ST_MISS;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_EIRD: begin
            state_in = S_EIWT;
         end
         S_EIWT: begin
            cmp_key_in = rd.key;
            if (cmd_ff == CMD_NEXT) begin
               cur_in = rd.link;
               prv_in = NIL;
               steps_in = '0;
               found_in = 1'b0;
               state_in = S_WRD;
            end else begin
               state_in = S_HRD;
            end
         end
         S_ER1: begin
            // unlink x from its chain
            if (prv_ff == NIL) begin
               head_wr.we = 1'b1;
               head_wr.data = xlink_ff;
            end else begin
               ent_wr.link_we = 1'b1;
               ent_wr.addr = prv_ff[IDX_W-1:0];
               ent_wr.link = xlink_ff;
            end
            ex_in = x_ff;
            if (x_ff == last) begin
               used_in = last;
               state_in = S_EDONE;
            end else begin
               cur_in = last;
               state_in = S_LRD;
            end
         end
         S_LRD: begin
            state_in = S_LWT;
         end
         S_LWT: begin
            cmp_key_in = rd.key;
            lastpred_in = 1'b1;
            state_in = S_HRD;
         end
         S_CRD: begin
            state_in = S_CWR;
         end
         S_CWR: begin
            // move the last entry into the hole
            ent_wr.key_we = 1'b1;
            ent_wr.link_we = 1'b1;
            ent_wr.val_we = 1'b1;
            ent_wr.addr = ex_ff[IDX_W-1:0];
            ent_wr.key = rd.key;
            ent_wr.link = rd.link;
            ent_wr.val = rd.val;
            used_in = last;
            state_in = S_EDONE;
         end
         S_EDONE: begin
            lastpred_in = 1'b0;
            if (cmd_ff == CMD_REMOVE_ALL) begin
               if (cnt_ff != '1) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               cmp_key_in = key_ff;
               state_in = S_HRD;
            end else begin
               state_in = S_RSP;
            end
         end
         S_ADD: begin
            ent_wr.key_we = 1'b1;
            ent_wr.link_we = 1'b1;
            ent_wr.val_we = 1'b1;
            ent_wr.addr = used_ff[IDX_W-1:0];
            ent_wr.key = key_ff;
            ent_wr.link = found_ff ? x_ff : NIL;
            ent_wr.val = val_ff;
            state_in = S_ADD2;
         end
         S_ADD2: begin
            if (prv_ff == NIL) begin
               head_wr.we = 1'b1;
               head_wr.data = used_ff;
            end else begin
               ent_wr.link_we = 1'b1;
               ent_wr.addr = prv_ff[IDX_W-1:0];
               ent_wr.link = used_ff;
            end
            used_in = used_ff + 1'b1;
            st_in = ST_OK;
            rs_in = used_ff[IDX_W-1:0];
            rv_in = val_ff;
            state_in = S_RSP;
         end
         S_RSP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = st_ff;
               rsp_in.value_out = rv_ff;
               rsp_in.slot_out = rs_ff;
               rsp_in.match_count = cnt_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         lastpred_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         steps_ff <= '0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         lastpred_ff <= lastpred_in;
         rsp_valid_ff <= rsp_valid_in;
         steps_ff <= steps_in;
      end
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      val_ff <= val_in;
      ei_ff <= ei_in;
      cmp_key_ff <= cmp_key_in;
      cur_ff <= cur_in;
      prv_ff <= prv_in;
      found_ff <= found_in;
      x_ff <= x_in;
      xlink_ff <= xlink_in;
      xval_ff <= xval_in;
      ex_ff <= ex_in;
      st_ff <= st_in;
      rv_ff <= rv_in;
      rs_ff <= rs_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= PTR_W'(ENTRIES))
      else $error("entry count above capacity");

   a_add_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ADD |-> used_ff < PTR_W'(ENTRIES))
      else $error("insert into a full table");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= PTR_W'(ENTRIES) || state_ff == S_IDLE)
      else $error("chain walk ran past its bound");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_item.command == CMD_CLEAR |=> used_ff == '0)
      else $error("clear left entries behind");

endmodule
`default_nettype wire

// ----- tb/tb_chained_hash_multimap_unit.sv -----
// testbench for chained_hash_multimap_unit: random and directed commands with a
// table predictor and an in-order result scoreboard; depends on chm_pkg and the unit
`timescale 1ns / 1ps
`default_nettype none

import chm_pkg::*;

class multimap_scoreboard;

   logic [PTR_W-1:0]   heads [BUCKETS];
   logic [KEY_W-1:0]   keys [ENTRIES];
   logic [PTR_W-1:0]   links [ENTRIES];
   logic [VALUE_W-1:0] vals [ENTRIES];
   int unsigned        live;
   rsp_type            pending [$];
   int                 errors;

   function new();
      foreach (heads[i]) heads[i] = NIL;
      foreach (keys[i]) begin
         keys[i] = '0;
         links[i] = '0;
         vals[i] = '0;
      end
      live = 0;
      errors = 0;
   endfunction

   function int unsigned bkt(logic [KEY_W-1:0] k);
      return k[BKT_W-1:0];
   endfunction

   function int unsigned find_key(logic [KEY_W-1:0] k, output int unsigned prev);
      int unsigned c, p, steps;
      c = heads[bkt(k)];
      p = NIL;
      steps = 0;
      while (c < live && steps < ENTRIES) begin
         if (keys[c] == k) begin
            prev = p;
            return c;
         end
         p = c;
         c = links[c];
         steps++;
      end
      prev = p;
      return NIL;
   endfunction

   function int unsigned find_pred(int unsigned x, output bit found);
      int unsigned c, p, steps;
      c = heads[bkt(keys[x])];
      p = NIL;
      steps = 0;
      while (c < live && steps < ENTRIES) begin
         if (c == x) begin
            found = 1;
            return p;
         end
         p = c;
         c = links[c];
         steps++;
      end
      found = 0;
      return NIL;
   endfunction

   function void erase(int unsigned x, int unsigned prev);
      int unsigned last, lp;
      bit ok;
      last = live - 1;
      if (prev == NIL) heads[bkt(keys[x])] = links[x];
      else links[prev] = links[x];
      if (x != last) begin
         lp = find_pred(last, ok);
         if (ok) begin
            if (lp == NIL) heads[bkt(keys[last])] = PTR_W'(x);
            else links[lp] = PTR_W'(x);
         end
         keys[x] = keys[last];
         links[x] = links[last];
         vals[x] = vals[last];
      end
      live = last;
   endfunction

   function int unsigned add_entry(logic [KEY_W-1:0] k, logic [31:0] v,
                                   int unsigned prev, int unsigned nxt);
      int unsigned n;
      n = live;
      keys[n] = k;
      vals[n] = v;
      links[n] = PTR_W'(nxt);
      if (prev == NIL) heads[bkt(k)] = PTR_W'(n);
      else links[prev] = PTR_W'(n);
      live = n + 1;
      return n;
   endfunction

   function void note_command(req_type r);
      rsp_type e;
      int unsigned x, prev, c, steps, cnt, ei;
      bit ok;
      e = '0;
      e.status = ST_MISS;
      cnt = 0;
      ei = r.slot_sel;
      case (r.command)
         CMD_GET: begin
            x = find_key(r.key, prev);
            if (x != NIL) begin
               e.status = ST_OK; e.slot_out = 7'(x); e.value_out = vals[x];
            end
         end
         CMD_SET: begin
            x = find_key(r.key, prev);
            if (x != NIL) vals[x] = r.value;
            else if (live < ENTRIES) x = add_entry(r.key, r.value, prev, NIL);
            if (x != NIL) begin
               e.status = ST_OK; e.slot_out = 7'(x); e.value_out = vals[x];
            end else e.status = ST_FULL;
         end
         CMD_REMOVE: begin
            x = find_key(r.key, prev);
            if (x != NIL) begin
               e.status = ST_OK; e.slot_out = 7'(x); e.value_out = vals[x];
               erase(x, prev);
            end
         end
         CMD_MULTI: begin
            if (live >= ENTRIES) e.status = ST_FULL;
            else begin
               x = find_key(r.key, prev);
               x = add_entry(r.key, r.value, prev, x);
               e.status = ST_OK; e.slot_out = 7'(x); e.value_out = vals[x];
            end
         end
         CMD_COUNT: begin
            c = heads[bkt(r.key)];
            steps = 0;
            while (c < live && steps < ENTRIES) begin
               if (keys[c] == r.key && cnt < 255) cnt++;
               c = links[c];
               steps++;
            end
            e.status = ST_OK;
         end
         CMD_NEXT: begin
            if (ei < live) begin
               c = links[ei];
               steps = 0;
               while (c < live && steps < ENTRIES) begin
                  if (keys[c] == keys[ei]) begin
                     e.status = ST_OK; e.slot_out = 7'(c); e.value_out = vals[c];
                     break;
                  end
                  c = links[c];
                  steps++;
               end
            end
         end
         CMD_REMOVE_ENTRY: begin
            if (ei < live) begin
               prev = find_pred(ei, ok);
               if (ok) begin
                  e.status = ST_OK; e.slot_out = 7'(ei); e.value_out = vals[ei];
                  erase(ei, prev);
               end
            end
         end
         CMD_CLEAR: begin
            foreach (heads[i]) heads[i] = NIL;
            live = 0;
            e.status = ST_OK;
         end
         CMD_REMOVE_ALL: begin
            for (int i = 0; i < ENTRIES; i++) begin
               x = find_key(r.key, prev);
               if (x == NIL) break;
               erase(x, prev);
               if (cnt < 255) cnt++;
            end
            e.status = (cnt != 0) ? ST_OK : ST_MISS;
         end
         default: ;
      endcase
      e.match_count = 8'(cnt);
      pending.push_back(e);
   endfunction

   function void check_result(rsp_type got);
      rsp_type e;
      if (pending.size() == 0) begin
         $error("result with nothing expected: %p", got);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
         $error("status: expected %0d, got %0d", e.status, got.status); errors++;
      end
      if (got.value_out !== e.value_out) begin
         $error("value_out: expected %h, got %h", e.value_out, got.value_out); errors++;
      end
      if (got.slot_out !== e.slot_out) begin
         $error("slot_out: expected %0d, got %0d", e.slot_out, got.slot_out); errors++;
      end
      if (got.match_count !== e.match_count) begin
         $error("match_count: expected %0d, got %0d", e.match_count, got.match_count);
         errors++;
      end
   endfunction
endclass

module tb_chained_hash_multimap_unit;
   import chm_pkg::*;

   localparam int WATCHDOG = 400000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_item;

   multimap_scoreboard board = new();
   logic [KEY_W-1:0] key_pool [16];
   int  idle_cycles = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   bit  stim_done = 0;

   chained_hash_multimap_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // accepted items feed the predictor; results are checked in order
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         board.note_command(req_item);
         items_sent++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_result(rsp_item);
         results_seen++;
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      int g;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         g = gap_length();
         if ($urandom_range(0, 9) < 3) g = 0;
         rsp_ready <= (g == 0);
         repeat (g > 0 ? g : 1) @(posedge clock);
         rsp_ready <= 1;
         @(posedge clock);
      end
   end

   task automatic send(input logic [3:0] cmd, input logic [KEY_W-1:0] k,
                       input logic [31:0] v, input logic [6:0] ei);
      req_type r;
      int g;
      g = gap_length();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      r.command = cmd;
      r.key = k;
      r.value = v;
      r.slot_sel = ei;
      req_item <= r;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
      return key_pool[$urandom_range(0, 15)];
   endfunction

   function automatic logic [6:0] pick_index();
      if (board.live > 0 && $urandom_range(0, 9) < 8)
         return 7'($urandom_range(0, board.live - 1));
      return 7'($urandom_range(0, 127));
   endfunction

   initial begin
      logic [3:0] cmd;
      int r;
      // a few buckets shared by several keys so chains grow
      for (int i = 0; i < 16; i++)
         key_pool[i] = {$urandom, 24'($urandom), 8'($urandom_range(0, 3))};
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed
      send(CMD_GET, '0, '0, '0);
      send(CMD_SET, '0, 32'hFFFF_FFFF, '0);
      send(CMD_SET, '1, '0, '0);
      send(CMD_MULTI, '0, 32'h1234_5678, '0);
      send(CMD_MULTI, 64'h100, 32'hA5A5_A5A5, '0);
      send(CMD_SET, 64'h100, 32'h5A5A_5A5A, '0);
      send(CMD_COUNT, '0, '0, '0);
      send(CMD_NEXT, '0, '0, 7'd0);
      send(CMD_NEXT, '0, '0, 7'd1);
      send(CMD_NEXT, '0, '0, 7'd127);
      send(CMD_GET, '1, '0, '0);
      send(CMD_REMOVE_ENTRY, '0, '0, 7'd0);
      send(CMD_REMOVE_ENTRY, '0, '0, 7'd127);
      send(CMD_REMOVE, '1, '0, '0);
      send(CMD_REMOVE, '1, '0, '0);
      send(CMD_REMOVE_ALL, '0, '0, '0);
      send(CMD_REMOVE_ALL, '0, '0, '0);
      send(4'd9, '1, '1, 7'h7F);
      send(4'd15, '0, '0, '0);
      send(CMD_CLEAR, '0, '0, '0);
      // fill the table to capacity, then overflow
      for (int i = 0; i < ENTRIES; i++) send(CMD_MULTI, 64'h200, $urandom, '0);
      send(CMD_MULTI, 64'h200, $urandom, '0);
      send(CMD_SET, 64'h300, $urandom, '0);
      send(CMD_SET, 64'h200, $urandom, '0);
      send(CMD_COUNT, 64'h200, '0, '0);
      send(CMD_REMOVE_ALL, 64'h200, '0, '0);

      // random
      for (int n = 0; n < 600; n++) begin
         r = $urandom_range(0, 99);
         if (r < 18) cmd = CMD_SET;
         else if (r < 36) cmd = CMD_MULTI;
         else if (r < 48) cmd = CMD_GET;
         else if (r < 56) cmd = CMD_REMOVE;
         else if (r < 64) cmd = CMD_COUNT;
         else if (r < 74) cmd = CMD_NEXT;
         else if (r < 84) cmd = CMD_REMOVE_ENTRY;
         else if (r < 89) cmd = CMD_REMOVE_ALL;
         else if (r < 91) cmd = CMD_CLEAR;
         else if (r < 93) cmd = 4'($urandom_range(9, 15));
         else cmd = CMD_MULTI;
         send(cmd, pick_key(), $urandom, pick_index());
      end
      req_valid <= 0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      $display("ran %0d commands with %0d results over all nine commands,", items_sent,
               results_seen);
      $display("unknown codes, full-table inserts and stale entry indexes");
      if (board.errors == 0 && board.pending.size() == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
`default_nettype wire
